FILE: rtl/core/rational_arithmetic_unit_macros.svh
// Assertion macros shared by the checker.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define RAU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked on every rising clock edge outside reset.
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/rau_pkg.sv
package rau_pkg;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_CMP = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   // Magnitudes are at most 2^62 plus carry; 64 bits hold every step.
   localparam int MagW = 64;

   typedef logic [MagW-1:0] mag_type;

   // Request to and answer from the shared divider.
   typedef struct packed {
      logic    start;
      mag_type dividend;
      mag_type divisor;
   } div_req_type;

   typedef struct packed {
      logic    done;
      mag_type quotient;
      mag_type remainder;
   } div_rsp_type;

endpackage

FILE: rtl/core/rau_divider.sv
// Restoring divider, one quotient bit per cycle.
module rau_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rau_pkg::div_req_type req,
   output rau_pkg::div_rsp_type rsp
);
   localparam int CntW = $clog2(rau_pkg::MagW + 1);

   logic                 busy_ff, busy_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   rau_pkg::mag_type     quo_ff, quo_in;
   rau_pkg::mag_type     rem_ff, rem_in;
   rau_pkg::mag_type     dvs_ff, dvs_in;
   logic                 done_ff, done_in;
   logic [rau_pkg::MagW:0] trial;
   logic [rau_pkg::MagW:0] shifted;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[rau_pkg::MagW-1]};
      trial   = shifted - {1'b0, dvs_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(rau_pkg::MagW);
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         if (!trial[rau_pkg::MagW]) begin
            rem_in = trial[rau_pkg::MagW-1:0];
            quo_in = {quo_ff[rau_pkg::MagW-2:0], 1'b1};
         end else begin
            rem_in = shifted[rau_pkg::MagW-1:0];
            quo_in = {quo_ff[rau_pkg::MagW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;
endmodule

FILE: rtl/core/rational_arithmetic_unit.sv
// Rational arithmetic unit.
// A request word on req_* carries an operation (add, subtract, multiply,
// divide or compare), two signed fractions and a reduce flag. One response
// word on rsp_* returns the result fraction with the sign on the numerator,
// a status and three compare flags. The block takes one word at a time:
// req_tready is high only while no request is in work and no response waits.
// Latency depends on the operation. Each greatest common divisor runs the
// Euclid loop on the shared restoring divider, and the quotients of
// reductions and of the common-denominator scaling use the same divider.
// Multiplications are split into 32x32 partial products, one per cycle,
// through a single registered multiplier.
// Reset is synchronous and active high; it drops any word in work and
// clears the response valid. When the receiver holds rsp_tready low the
// response stays stable and no new request is accepted.
module rational_arithmetic_unit #(
   parameter int WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96], reduce[128],
   // zero fill up to bit 135
   input  logic [135:0] req_tdata,
   // req_type[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // res_num[31:0], res_den[62:32], status[64:63], less[65], greater[66],
   // equal[67], zero fill up to bit 71
   output logic [71:0]  rsp_tdata
);
   localparam int EffW = (WIDTH > 32) ? 32 : WIDTH;
   localparam int MW   = rau_pkg::MagW;

   // Sequencer states.
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_MUL   = 5'd1;  // partial products
   localparam logic [4:0] S_GSTEP = 5'd2;  // launch x % y
   localparam logic [4:0] S_GWAIT = 5'd3;
   localparam logic [4:0] S_QSTEP = 5'd4;  // launch quotient
   localparam logic [4:0] S_QWAIT = 5'd5;
   localparam logic [4:0] S_DISP  = 5'd6;  // pick next micro step
   localparam logic [4:0] S_OUT   = 5'd7;

   // Micro program steps.
   localparam logic [3:0] P_START  = 4'd0;
   localparam logic [3:0] P_REDA   = 4'd1;
   localparam logic [3:0] P_REDB   = 4'd2;
   localparam logic [3:0] P_GDEN   = 4'd3;
   localparam logic [3:0] P_LCM    = 4'd4;
   localparam logic [3:0] P_SCA    = 4'd5;
   localparam logic [3:0] P_SCB    = 4'd6;
   localparam logic [3:0] P_SUM    = 4'd7;
   localparam logic [3:0] P_REDR   = 4'd8;
   localparam logic [3:0] P_FIN    = 4'd9;
   localparam logic [3:0] P_MULN   = 4'd10;
   localparam logic [3:0] P_MULD   = 4'd11;
   localparam logic [3:0] P_CMPX   = 4'd12;
   localparam logic [3:0] P_CMPY   = 4'd13;
   localparam logic [3:0] P_CMPF   = 4'd14;

   logic [4:0]       state_ff, state_in;
   logic [3:0]       step_ff, step_in;
   logic [2:0]       op_ff, op_in;
   logic             red_ff, red_in;
   logic             an_ff, an_in, bn_ff, bn_in, rn_ff, rn_in;
   rau_pkg::mag_type am_ff, am_in, ad_ff, ad_in, bm_ff, bm_in, bd_ff, bd_in;
   rau_pkg::mag_type rm_ff, rm_in, rd_ff, rd_in;
   rau_pkg::mag_type lcm_ff, lcm_in, t_ff, t_in;
   // gcd working pair; gx is also the divisor of each quotient
   rau_pkg::mag_type gx_ff, gx_in, gy_ff, gy_in;
   rau_pkg::mag_type qa_ff, qa_in;   // other quotient operand
   logic [1:0]       qphase_ff, qphase_in;
   // multiplier
   rau_pkg::mag_type mx_ff, mx_in, my_ff, my_in, macc_ff, macc_in;
   logic [1:0]       mph_ff, mph_in;
   logic [63:0]      prod_ff;
   logic [31:0]      pa, pb;
   logic [3:0]       mret_ff, mret_in;
   logic             vld_ff, vld_in;
   logic [71:0]      out_ff, out_in;
   rau_pkg::div_req_type dreq;
   rau_pkg::div_rsp_type drsp;

   // operand normalization
   logic signed [32:0] na, da, nb, db;
   logic               fits_ok;
   rau_pkg::mag_type   lim;
   logic signed [MW:0] cx, cy;

   rau_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   always_comb begin
      na = 33'(signed'(req_tdata[31:0]));
      da = 33'(signed'(req_tdata[63:32]));
      nb = 33'(signed'(req_tdata[95:64]));
      db = 33'(signed'(req_tdata[127:96]));
      if (da == 0) begin
         na = '0;
         da = 33'sd1;
      end
      if (db == 0) begin
         nb = '0;
         db = 33'sd1;
      end
      if (da < 0) begin
         na = -na;
         da = -da;
      end
      if (db < 0) begin
         nb = -nb;
         db = -db;
      end
   end

   // One 32x32 partial product a cycle, selected by phase.
   assign pa = mph_ff[0] ? mx_ff[63:32] : mx_ff[31:0];
   assign pb = mph_ff[1] ? my_ff[63:32] : my_ff[31:0];

   always_ff @(posedge clock) begin
      prod_ff <= 64'(pa) * 64'(pb);
   end

   assign lim = MW'(1) << (EffW - 1);
   always_comb begin
      fits_ok = (rd_ff >= MW'(1)) && (rd_ff <= lim - 1'b1) &&
                (rn_ff ? (rm_ff <= lim) : (rm_ff <= lim - 1'b1));
   end

   // Signed compare products: x is held in lcm_ff, y in the accumulator.
   assign cx = an_ff ? -$signed({1'b0, lcm_ff}) : $signed({1'b0, lcm_ff});
   assign cy = bn_ff ? -$signed({1'b0, macc_ff}) : $signed({1'b0, macc_ff});

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      op_in     = op_ff;
      red_in    = red_ff;
      an_in     = an_ff;
      bn_in     = bn_ff;
      rn_in     = rn_ff;
      am_in     = am_ff;
      ad_in     = ad_ff;
      bm_in     = bm_ff;
      bd_in     = bd_ff;
      rm_in     = rm_ff;
      rd_in     = rd_ff;
      lcm_in    = lcm_ff;
      t_in      = t_ff;
      gx_in     = gx_ff;
      gy_in     = gy_ff;
      qa_in     = qa_ff;
      qphase_in = qphase_ff;
      mx_in     = mx_ff;
      my_in     = my_ff;
      macc_in   = macc_ff;
      mph_in    = mph_ff;
      mret_in   = mret_ff;
      vld_in    = vld_ff;
      out_in    = out_ff;
      dreq      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (vld_ff && rsp_tready) begin
               vld_in = 1'b0;
            end
            if (req_tvalid && req_tready) begin
               op_in  = req_tuser;
               red_in = req_tdata[128];
               an_in  = na < 0;
               bn_in  = nb < 0;
               am_in  = MW'(na < 0 ? -na : na);
               bm_in  = MW'(nb < 0 ? -nb : nb);
               ad_in  = MW'(da);
               bd_in  = MW'(db);
               step_in  = P_START;
               state_in = S_DISP;
            end
         end

         S_MUL: begin
            // Phase 0 issues the low product; phases 1 to 3 add in the
            // product that the previous phase issued. The high-high product lies
            // wholly above bit 63 and is never needed.
            unique case (mph_ff)
               2'd0: begin
                  macc_in = '0;
                  mph_in  = 2'd1;
               end
               2'd1: begin
                  macc_in = macc_ff + prod_ff;
                  mph_in  = 2'd2;
               end
               2'd2: begin
                  macc_in = macc_ff + {prod_ff[31:0], 32'd0};
                  mph_in  = 2'd3;
               end
               2'd3: begin
                  macc_in = macc_ff + {prod_ff[31:0], 32'd0};
                  mph_in  = 2'd0;
                  step_in = mret_ff;
                  state_in = S_DISP;
               end
            endcase
         end

         S_GSTEP: begin
            if (gy_ff == '0) begin
               // gcd now in gx; divide the pair by it
               qphase_in = 2'd0;
               state_in  = S_QSTEP;
            end else begin
               dreq.start    = 1'b1;
               dreq.dividend = gx_ff;
               dreq.divisor  = gy_ff;
               state_in      = S_GWAIT;
            end
         end

         S_GWAIT: begin
            if (drsp.done) begin
               gx_in    = gy_ff;
               gy_in    = drsp.remainder;
               state_in = S_GSTEP;
            end
         end

         S_QSTEP: begin
            dreq.start    = 1'b1;
            dreq.dividend = (qphase_ff == 2'd0) ? t_ff : qa_ff;
            dreq.divisor  = gx_ff;
            state_in      = S_QWAIT;
         end

         S_QWAIT: begin
            if (drsp.done) begin
               if (qphase_ff == 2'd0) begin
                  t_in      = drsp.quotient;
                  qphase_in = 2'd1;
                  state_in  = S_QSTEP;
               end else begin
                  qa_in    = drsp.quotient;
                  state_in = S_DISP;
               end
            end
         end

         S_DISP: begin
            unique case (step_ff) inside
               P_START: begin
                  unique case (op_ff) inside
                     rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                        if (op_ff == rau_pkg::OP_SUB) begin
                           bn_in = ~bn_ff;
                        end
                        step_in = red_ff ? P_REDA : P_GDEN;
                     end
                     rau_pkg::OP_MUL: begin
                        rn_in   = an_ff ^ bn_ff;
                        mx_in   = am_ff;
                        my_in   = bm_ff;
                        t_in    = '0;
                        macc_in = '0;
                        mph_in  = 2'd0;
                        mret_in = P_MULN;
                        state_in = S_MUL;
                     end
                     rau_pkg::OP_DIV: begin
                        if (bm_ff == '0) begin
                           rn_in = an_ff;
                           rm_in = am_ff;
                           rd_in = ad_ff;
                           step_in = P_FIN;
                        end else begin
                           rn_in   = an_ff ^ bn_ff;
                           bm_in   = bd_ff;
                           bd_in   = bm_ff;
                           mx_in   = am_ff;
                           my_in   = bd_ff;
                           t_in    = '0;
                           macc_in = '0;
                           mph_in  = 2'd0;
                           mret_in = P_MULN;
                           state_in = S_MUL;
                        end
                     end
                     rau_pkg::OP_CMP: begin
                        mx_in   = am_ff;
                        my_in   = bd_ff;
                        t_in    = '0;
                        macc_in = '0;
                        mph_in  = 2'd0;
                        mret_in = P_CMPX;
                        state_in = S_MUL;
                     end
                     default: begin
                        out_in   = '0;
                        out_in[62:32] = 31'd1;
                        state_in = S_OUT;
                     end
                  endcase
               end

               P_MULN: begin
                  rm_in   = macc_ff;
                  mx_in   = ad_ff;
                  my_in   = bd_ff;
                  t_in    = '0;
                  macc_in = '0;
                  mret_in = P_MULD;
                  state_in = S_MUL;
               end

               P_MULD: begin
                  rd_in = macc_ff;
                  if (rm_ff == '0) begin
                     rn_in = 1'b0;
                  end
                  step_in = red_ff ? P_REDR : P_FIN;
               end

               P_CMPX: begin
                  // Keep x across the second product.
                  lcm_in  = macc_ff;
                  mx_in   = bm_ff;
                  my_in   = ad_ff;
                  macc_in = '0;
                  mret_in = P_CMPY;
                  state_in = S_MUL;
               end

               P_CMPY: begin
                  // x sits in lcm_ff, y in the accumulator.
                  step_in = P_CMPF;
               end

               P_CMPF: begin
                  out_in = '0;
                  out_in[62:32] = 31'd1;
                  out_in[65] = cx < cy;
                  out_in[66] = cx > cy;
                  out_in[67] = cx == cy;
                  state_in = S_OUT;
               end

               P_REDA, P_REDB, P_REDR: begin
                  // Reduce one fraction: gcd(mag, den), then divide both.
                  if (qphase_ff == 2'd1) begin
                     qphase_in = 2'd0;
                     if (step_ff == P_REDA) begin
                        am_in = t_ff;
                        ad_in = qa_ff;
                        step_in = P_REDB;
                     end else if (step_ff == P_REDB) begin
                        bm_in = t_ff;
                        bd_in = qa_ff;
                        step_in = P_GDEN;
                     end else begin
                        rm_in = t_ff;
                        rd_in = qa_ff;
                        step_in = P_FIN;
                     end
                  end else begin
                     if (step_ff == P_REDA) begin
                        t_in = am_ff; qa_in = ad_ff;
                     end else if (step_ff == P_REDB) begin
                        t_in = bm_ff; qa_in = bd_ff;
                     end else begin
                        t_in = rm_ff; qa_in = rd_ff;
                     end
                     gx_in = (step_ff == P_REDA) ? am_ff :
                             (step_ff == P_REDB) ? bm_ff : rm_ff;
                     gy_in = (step_ff == P_REDA) ? ad_ff :
                             (step_ff == P_REDB) ? bd_ff : rd_ff;
                     if (gx_in == '0) begin
                        // zero numerator reduces to 0/1
                        if (step_ff == P_REDA) begin
                           an_in = 1'b0; ad_in = MW'(1); step_in = P_REDB;
                        end else if (step_ff == P_REDB) begin
                           bn_in = 1'b0; bd_in = MW'(1); step_in = P_GDEN;
                        end else begin
                           rn_in = 1'b0; rd_in = MW'(1); step_in = P_FIN;
                        end
                     end else begin
                        state_in = S_GSTEP;
                     end
                  end
               end

               P_GDEN: begin
                  if (qphase_ff == 2'd1) begin
                     // t = ad/g, qa = bd/g
                     qphase_in = 2'd0;
                     lcm_in  = qa_ff;       // bd/g scales a
                     mx_in   = t_ff;
                     my_in   = bd_ff;
                     t_in    = '0;
                     macc_in = '0;
                     mret_in = P_LCM;
                     state_in = S_MUL;
                  end else begin
                     t_in  = ad_ff;
                     qa_in = bd_ff;
                     gx_in = ad_ff;
                     gy_in = bd_ff;
                     state_in = S_GSTEP;
                  end
               end

               P_LCM: begin
                  rd_in   = macc_ff;      // lcm
                  mx_in   = am_ff;
                  my_in   = lcm_ff;
                  macc_in = '0;
                  mret_in = P_SCA;
                  state_in = S_MUL;
               end

               P_SCA: begin
                  am_in = macc_ff;
                  // b scale = lcm / bd
                  qa_in = rd_ff;
                  gx_in = bd_ff;
                  qphase_in = 2'd1;
                  state_in = S_QSTEP;
                  step_in = P_SCB;
               end

               P_SCB: begin
                  mx_in   = bm_ff;
                  my_in   = qa_ff;
                  macc_in = '0;
                  mret_in = P_SUM;
                  state_in = S_MUL;
                  qphase_in = 2'd0;
               end

               P_SUM: begin
                  if (an_ff == bn_ff) begin
                     rn_in = an_ff;
                     rm_in = am_ff + macc_ff;
                  end else if (am_ff >= macc_ff) begin
                     rn_in = an_ff;
                     rm_in = am_ff - macc_ff;
                  end else begin
                     rn_in = bn_ff;
                     rm_in = macc_ff - am_ff;
                  end
                  if (rm_in == '0) begin
                     rn_in = 1'b0;
                  end
                  step_in = red_ff ? P_REDR : P_FIN;
               end

               P_FIN: begin
                  out_in = '0;
                  if (fits_ok) begin
                     out_in[31:0]  = rn_ff ? 32'(-rm_ff) : rm_ff[31:0];
                     out_in[62:32] = rd_ff[30:0];
                     out_in[64:63] = (op_ff == rau_pkg::OP_DIV && bm_ff == '0) ?
                                     rau_pkg::ST_DIV0 : rau_pkg::ST_OK;
                  end else begin
                     out_in[62:32] = 31'd1;
                     out_in[64:63] = rau_pkg::ST_OVF;
                  end
                  state_in = S_OUT;
               end

               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_OUT: begin
            vld_in   = 1'b1;
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         vld_ff    <= 1'b0;
         qphase_ff <= 2'd0;
         mph_ff    <= 2'd0;
      end else begin
         state_ff  <= state_in;
         vld_ff    <= vld_in;
         qphase_ff <= qphase_in;
         mph_ff    <= mph_in;
      end
      step_ff <= step_in;
      op_ff   <= op_in;
      red_ff  <= red_in;
      an_ff   <= an_in;
      bn_ff   <= bn_in;
      rn_ff   <= rn_in;
      am_ff   <= am_in;
      ad_ff   <= ad_in;
      bm_ff   <= bm_in;
      bd_ff   <= bd_in;
      rm_ff   <= rm_in;
      rd_ff   <= rd_in;
      lcm_ff  <= lcm_in;
      t_ff    <= t_in;
      gx_ff   <= gx_in;
      gy_ff   <= gy_in;
      qa_ff   <= qa_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      macc_ff <= macc_in;
      mret_ff <= mret_in;
      out_ff  <= out_in;
   end

   assign req_tready = (state_ff == S_IDLE) && !vld_ff;
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = out_ff;
endmodule

FILE: rtl/core/rau_checker.sv
`include "rational_arithmetic_unit_macros.svh"

module rau_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [71:0]  rsp_tdata
);
   `RAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response dropped or changed while stalled")
   `RAU_ASSERT_IMPL(a_no_accept_busy, clock, reset, rsp_tvalid, !req_tready, "request accepted while response pending")
   `RAU_ASSERT_IMPL(a_den_positive, clock, reset, rsp_tvalid, rsp_tdata[62:32] != 31'd0, "zero result denominator")
   `RAU_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready, "ready stayed high after accept")
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
